// ===== hw/rtl/b32m_pkg.sv =====
// shared types, constants and checksum helpers for the bech32m encoder
`timescale 1ns / 1ps

package b32m_pkg;

   // hrp buffer sizing
   localparam int HRP_DEPTH = 83;
   localparam int LEN_W     = $clog2(HRP_DEPTH + 1);
   localparam int ADDR_W    = (HRP_DEPTH > 1) ? $clog2(HRP_DEPTH) : 1;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // request type codes on the input channel
   localparam logic [1:0] REQ_HRP  = 2'd0;
   localparam logic [1:0] REQ_DATA = 2'd1;
   localparam logic [1:0] REQ_END  = 2'd2;

   // checksum constants
   localparam logic [29:0] CHK_INIT  = 30'h1;
   localparam logic [29:0] CHK_XOR_M = 30'h2bc830a3;
   localparam logic [29:0] GEN_POLY [5] = '{
      30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
   };

   localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
   localparam logic [7:0]   SEP_CHAR = "1";

   typedef enum logic [1:0] {
      KIND_HRP,
      KIND_DATA,
      KIND_END
   } item_kind_type;

   // classified request handed from front to back
   typedef struct packed {
      item_kind_type kind;
      logic [7:0]    data;
      logic          first;
   } q_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HRP,
      ST_SEP,
      ST_WALK,
      ST_DATA,
      ST_PAD,
      ST_ZERO,
      ST_CHK
   } back_state_type;

   // one bch step: shift in a 5-bit symbol and reduce
   function automatic logic [29:0] fold(input logic [29:0] chk, input logic [4:0] sym);
      logic [29:0] c;
      c = {chk[24:0], sym};
      for (int i = 0; i < 5; i++) begin
         if (chk[25 + i]) begin
            c = c ^ GEN_POLY[i];
         end
      end
      return c;
   endfunction

   // 5-bit symbol to ascii
   function automatic logic [7:0] sym_char(input logic [4:0] sym);
      logic [7:0] ch;
      ch = CHARSET[(8'd31 - {3'd0, sym}) * 8 +: 8];
      return ch;
   endfunction

endpackage

// ===== hw/rtl/b32m_if.sv =====
// valid/ready channel interfaces for requests and encoded characters
`timescale 1ns / 1ps

interface b32m_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] req_in_byte;

   modport source (output valid, output req_type, output req_in_byte, input ready);
   modport sink   (input valid, input req_type, input req_in_byte, output ready);
endinterface

interface b32m_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] rsp_out_char;
   logic       rsp_end_of_string;
   logic       rsp_hrp_overflow;

   modport source (output valid, output rsp_out_char, output rsp_end_of_string,
                   output rsp_hrp_overflow, input ready);
   modport sink   (input valid, input rsp_out_char, input rsp_end_of_string,
                   input rsp_hrp_overflow, output ready);
endinterface

// ===== hw/rtl/b32m_front.sv =====
// request intake: classifies requests, drops ignored ones, queues the rest
`timescale 1ns / 1ps

module b32m_front (
   input  logic                 clock,
   input  logic                 reset,
   b32m_req_if.sink             req,
   output logic                 q_valid,
   output b32m_pkg::q_item_type q_item,
   input  logic                 q_pop
);

   b32m_pkg::q_item_type q_mem_ff [b32m_pkg::QUEUE_DEPTH];
   logic [b32m_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [b32m_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [b32m_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   logic                        phase_ff, phase_in;
   logic                        accept;
   logic                        keep;
   logic                        push;
   b32m_pkg::q_item_type        new_item;

   assign req.ready = (cnt_ff != b32m_pkg::QCNT_W'(b32m_pkg::QUEUE_DEPTH));
   assign accept    = req.valid & req.ready;
   assign q_valid   = (cnt_ff != '0);
   assign q_item    = q_mem_ff[rd_ptr_ff];

   // classify the request
   always_comb begin
      keep          = 1'b0;
      phase_in      = phase_ff;
      new_item.kind = b32m_pkg::KIND_HRP;
      new_item.data = req.req_in_byte;
      new_item.first = ~phase_ff;
      case (req.req_type)
         b32m_pkg::REQ_HRP: begin
            keep = ~phase_ff;
         end
         b32m_pkg::REQ_DATA: begin
            keep          = 1'b1;
            new_item.kind = b32m_pkg::KIND_DATA;
            if (accept) phase_in = 1'b1;
         end
         b32m_pkg::REQ_END: begin
            keep          = 1'b1;
            new_item.kind = b32m_pkg::KIND_END;
            if (accept) phase_in = 1'b0;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      push = accept & keep;
   end

   // queue pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == b32m_pkg::QPTR_W'(b32m_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == b32m_pkg::QPTR_W'(b32m_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         phase_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
         phase_ff  <= phase_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== hw/rtl/b32m_back.sv =====
// encode sequencer: checksum, hrp buffer walk, 8-to-5 regroup, output register
`timescale 1ns / 1ps

module b32m_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  b32m_pkg::q_item_type q_item,
   output logic                 q_pop,
   b32m_rsp_if.source           rsp
);

   b32m_pkg::back_state_type state_ff, state_in;
   b32m_pkg::q_item_type     cur_ff, cur_in;
   logic [29:0]              chk_ff, chk_in;
   logic [29:0]              mod_ff, mod_in;
   logic [b32m_pkg::LEN_W-1:0] len_ff, len_in;
   logic [b32m_pkg::LEN_W-1:0] walk_ff, walk_in;
   logic [b32m_pkg::LEN_W-1:0] walk_nx;
   logic                     ovf_ff, ovf_in;
   logic [3:0]               left_ff, left_in;
   logic [2:0]               lcnt_ff, lcnt_in;
   logic [11:0]              acc_ff, acc_in;
   logic [3:0]               bits_ff, bits_in;
   logic [3:0]               bits_nx;
   logic [2:0]               step_ff, step_in;
   logic [4:0]               sym;
   logic [4:0]               pad_sym;
   logic [29:0]              zero_fold;

   // output register
   logic                     out_valid_ff;
   logic [7:0]               out_char_ff;
   logic                     out_eos_ff;
   logic                     out_ovf_ff;
   logic                     emit_ok;
   logic                     emit;
   logic [7:0]               emit_char;
   logic                     emit_eos;
   logic                     emit_ovf;

   // hrp low-part buffer
   logic [4:0]               hrp_mem [b32m_pkg::HRP_DEPTH];
   logic                     wr_en;
   logic [b32m_pkg::ADDR_W-1:0] wr_addr;
   logic                     rd_en;
   logic [b32m_pkg::ADDR_W-1:0] rd_addr;
   logic [4:0]               rd_data_ff;

   assign emit_ok = ~out_valid_ff | rsp.ready;
   assign walk_nx = walk_ff + 1'b1;
   assign bits_nx = bits_ff - 4'd5;
   assign sym     = 5'(acc_ff >> bits_nx);
   assign pad_sym = 5'({1'b0, left_ff} << (3'd5 - lcnt_ff));
   assign zero_fold = b32m_pkg::fold(chk_ff, 5'd0);

   assign rsp.valid             = out_valid_ff;
   assign rsp.rsp_out_char      = out_char_ff;
   assign rsp.rsp_end_of_string = out_eos_ff;
   assign rsp.rsp_hrp_overflow  = out_ovf_ff;

   // next state and datapath
   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      chk_in    = chk_ff;
      mod_in    = mod_ff;
      len_in    = len_ff;
      walk_in   = walk_ff;
      ovf_in    = ovf_ff;
      left_in   = left_ff;
      lcnt_in   = lcnt_ff;
      acc_in    = acc_ff;
      bits_in   = bits_ff;
      step_in   = step_ff;
      q_pop     = 1'b0;
      emit      = 1'b0;
      emit_char = 8'd0;
      emit_eos  = 1'b0;
      emit_ovf  = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = len_ff[b32m_pkg::ADDR_W-1:0];
      rd_en     = 1'b0;
      rd_addr   = walk_nx[b32m_pkg::ADDR_W-1:0];

      case (state_ff)
         // take the next queued request
         b32m_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               acc_in  = {left_ff, q_item.data};
               bits_in = {1'b0, lcnt_ff} + 4'd8;
               if (q_item.kind == b32m_pkg::KIND_HRP) begin
                  state_in = b32m_pkg::ST_HRP;
               end else if (q_item.first) begin
                  state_in = b32m_pkg::ST_SEP;
               end else if (q_item.kind == b32m_pkg::KIND_DATA) begin
                  state_in = b32m_pkg::ST_DATA;
               end else begin
                  state_in = b32m_pkg::ST_PAD;
               end
            end
         end

         // echo hrp char, fold high bits, keep low bits
         b32m_pkg::ST_HRP: begin
            if (emit_ok) begin
               emit      = 1'b1;
               emit_char = cur_ff.data;
               chk_in    = b32m_pkg::fold(chk_ff, {2'b00, cur_ff.data[7:5]});
               if (len_ff < b32m_pkg::LEN_W'(b32m_pkg::HRP_DEPTH)) begin
                  wr_en  = 1'b1;
                  len_in = len_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               state_in = b32m_pkg::ST_IDLE;
            end
         end

         // separator, fold zero, start buffer read
         b32m_pkg::ST_SEP: begin
            rd_addr = '0;
            if (emit_ok) begin
               emit      = 1'b1;
               emit_char = b32m_pkg::SEP_CHAR;
               chk_in    = zero_fold;
               rd_en     = (len_ff != '0);
               walk_in   = '0;
               if (len_ff != '0) begin
                  state_in = b32m_pkg::ST_WALK;
               end else if (cur_ff.kind == b32m_pkg::KIND_DATA) begin
                  state_in = b32m_pkg::ST_DATA;
               end else begin
                  state_in = b32m_pkg::ST_PAD;
               end
            end
         end

         // fold stored low parts, one per cycle
         b32m_pkg::ST_WALK: begin
            chk_in  = b32m_pkg::fold(chk_ff, rd_data_ff);
            walk_in = walk_nx;
            rd_en   = (walk_nx < len_ff);
            if (walk_nx == len_ff) begin
               if (cur_ff.kind == b32m_pkg::KIND_DATA) begin
                  state_in = b32m_pkg::ST_DATA;
               end else begin
                  state_in = b32m_pkg::ST_PAD;
               end
            end
         end

         // regroup data bits, one symbol per cycle while the output register can take it
         b32m_pkg::ST_DATA: begin
            if (emit_ok) begin
               emit      = 1'b1;
               emit_char = b32m_pkg::sym_char(sym);
               chk_in    = b32m_pkg::fold(chk_ff, sym);
               bits_in   = bits_nx;
               if (bits_nx < 4'd5) begin
                  lcnt_in  = bits_nx[2:0];
                  left_in  = acc_ff[3:0] & ((4'd1 << bits_nx) - 4'd1);
                  state_in = b32m_pkg::ST_IDLE;
               end
            end
         end

         // zero-padded final symbol if bits remain
         b32m_pkg::ST_PAD: begin
            step_in = '0;
            if (lcnt_ff == '0) begin
               state_in = b32m_pkg::ST_ZERO;
            end else if (emit_ok) begin
               emit      = 1'b1;
               emit_char = b32m_pkg::sym_char(pad_sym);
               chk_in    = b32m_pkg::fold(chk_ff, pad_sym);
               state_in  = b32m_pkg::ST_ZERO;
            end
         end

         // six zero folds, then apply the bech32m constant
         b32m_pkg::ST_ZERO: begin
            chk_in  = zero_fold;
            step_in = step_ff + 1'b1;
            if (step_ff == 3'd5) begin
               mod_in   = zero_fold ^ b32m_pkg::CHK_XOR_M;
               step_in  = '0;
               state_in = b32m_pkg::ST_CHK;
            end
         end

         // six checksum chars, high group first
         b32m_pkg::ST_CHK: begin
            if (emit_ok) begin
               emit      = 1'b1;
               emit_char = b32m_pkg::sym_char(mod_ff[29:25]);
               mod_in    = {mod_ff[24:0], 5'd0};
               step_in   = step_ff + 1'b1;
               if (step_ff == 3'd5) begin
                  emit_eos = 1'b1;
                  emit_ovf = ovf_ff;
                  len_in   = '0;
                  chk_in   = b32m_pkg::CHK_INIT;
                  left_in  = '0;
                  lcnt_in  = '0;
                  ovf_in   = 1'b0;
                  step_in  = '0;
                  state_in = b32m_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = b32m_pkg::ST_IDLE;
         end
      endcase
   end

   // control and message state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= b32m_pkg::ST_IDLE;
         chk_ff       <= b32m_pkg::CHK_INIT;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         left_ff      <= '0;
         lcnt_ff      <= '0;
         step_ff      <= '0;
         walk_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         chk_ff   <= chk_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
         left_ff  <= left_in;
         lcnt_ff  <= lcnt_in;
         step_ff  <= step_in;
         walk_ff  <= walk_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      mod_ff  <= mod_in;
      acc_ff  <= acc_in;
      bits_ff <= bits_in;
      if (emit) begin
         out_char_ff <= emit_char;
         out_eos_ff  <= emit_eos;
         out_ovf_ff  <= emit_ovf;
      end
   end

   // hrp buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hrp_mem[wr_addr] <= cur_ff.data[4:0];
      end
      if (rd_en) begin
         rd_data_ff <= hrp_mem[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/bech32m_encoder.sv =====
// top level of the streaming bech32m encoder
`timescale 1ns / 1ps
//
// Requests enter on req (valid/ready): req_type selects an hrp character, a
// data byte or end of message; req_in_byte carries the character or byte.
// Encoded ascii characters leave on rsp (valid/ready), one per transfer;
// rsp_end_of_string marks the last checksum character and rsp_hrp_overflow
// on that character reports an hrp longer than the buffer.
// A two-entry queue sits between intake and the encode sequencer, so
// requests keep flowing while the sequencer waits on the receiver.
// Each request is fetched from the queue; then an hrp character is echoed,
// a data byte gives one character per 5-bit symbol, and end of message
// gives the pad symbol if bits remain, six zero folds and six checksum
// characters. The first data byte or end also emits the separator and walks
// the hrp buffer, one entry per cycle. A request reaches the output register
// through the queue and the sequencer state.
// Reset (synchronous) empties the queue and output register and starts a
// fresh message. A stalled receiver holds the current character; the
// sequencer waits and the queue fills, then req.ready drops.
//

module bech32m_encoder (
   input  logic         clock,
   input  logic         reset,
   b32m_req_if.sink     req,
   b32m_rsp_if.source   rsp
);

   logic                 q_valid;
   logic                 q_pop;
   b32m_pkg::q_item_type q_item;

   b32m_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   b32m_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

endmodule

// ===== hw/rtl/b32m_checker.sv =====
// port-level assertions for the bech32m encoder, bound to the top level
`timescale 1ns / 1ps

module b32m_checker (
   input  logic       clock,
   input  logic       reset,
   b32m_req_if.sink   req,
   b32m_rsp_if.source rsp
);

   // a waiting request holds until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req.valid && !req.ready |=> req.valid && $stable(req.req_type)
         && $stable(req.req_in_byte))
      else $error("request changed while waiting");

   // a stalled character holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.rsp_out_char)
         && $stable(rsp.rsp_end_of_string) && $stable(rsp.rsp_hrp_overflow))
      else $error("rsp payload changed while stalled");

   // overflow is only reported on the final character
   a_ovf_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.rsp_hrp_overflow |-> rsp.rsp_end_of_string)
      else $error("hrp overflow flagged before end of string");

   // nothing is presented right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("rsp valid right after reset");

   // the separator is never the final character
   a_last_not_sep: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.rsp_end_of_string |-> rsp.rsp_out_char != b32m_pkg::SEP_CHAR)
      else $error("end of string on separator");

endmodule

bind bech32m_encoder b32m_checker u_b32m_checker (
   .clock (clock),
   .reset (reset),
   .req   (req),
   .rsp   (rsp)
);
